// ===== hw/rtl/cbxt_pkg.sv =====
// cbxt_pkg: request, status and write codes plus the controller/datapath
// command and status structs of the counting binary xor trie
// no dependencies
package cbxt_pkg;

	localparam int VALUE_W  = 30;
	localparam int STATUS_W = 2;
	localparam int REQ_W    = 3;

	localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_COUNT  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_MINX   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_MAXX   = 3'd4;
	localparam logic [REQ_W-1:0] REQ_MEX    = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_SAT    = 2'd3;

	typedef logic [2:0] wr_t;
	localparam wr_t WR_NONE = 3'd0;
	localparam wr_t WR_INC  = 3'd1;
	localparam wr_t WR_DEC  = 3'd2;
	localparam wr_t WR_LINK = 3'd3;
	localparam wr_t WR_NEW  = 3'd4;

	typedef struct packed {
		logic                ld;
		logic                root;
		logic                rd;
		logic                rd_alt;
		logic                adv;
		wr_t                 wr;
		logic                ans_bit;
		logic                ans_clr;
		logic                ans_cnt;
		logic                need_set;
		logic                st_we;
		logic [STATUS_W-1:0] st;
		logic                out_ld;
	} cmd_t;

	typedef struct packed {
		logic [REQ_W-1:0] op;
		logic             pref_zero;
		logic             alt_zero;
		logic             rd_live;
		logic             rd_sat;
		logic             mex_lo;
		logic             lvl_zero;
		logic             lvl_top;
		logic             fit;
		logic             out_busy;
	} sts_t;

endpackage

// ===== hw/rtl/cbxt_dp.sv =====
// cbxt_dp: trie datapath with node memory, root links, walk registers
// and result register; driven by commands from cbxt_ctrl, uses cbxt_pkg
module cbxt_dp #(
	parameter int KEY_BITS   = 30,
	parameter int POOL_NODES = 4096,
	parameter int COUNT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [cbxt_pkg::REQ_W-1:0]    req_type,
	input  logic [cbxt_pkg::VALUE_W-1:0]  key,
	input  cbxt_pkg::cmd_t                cmd,
	output cbxt_pkg::sts_t                sts,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [cbxt_pkg::VALUE_W-1:0]  value,
	output logic [cbxt_pkg::STATUS_W-1:0] status
);
	import cbxt_pkg::*;

	localparam int AW = $clog2(POOL_NODES);
	localparam int LW = $clog2(KEY_BITS);
	localparam int NW = AW + 1;
	localparam int MW = KEY_BITS + COUNT_BITS;

	typedef struct packed {
		logic [AW-1:0]         zc;
		logic [AW-1:0]         oc;
		logic [COUNT_BITS-1:0] cnt;
	} node_t;

	node_t node_mem [POOL_NODES];

	logic [REQ_W-1:0]    op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [LW-1:0]       lvl_q;
	logic [AW-1:0]       cur_idx_q;
	node_t               cur_q;
	logic [KEY_BITS-1:0] ans_q;
	logic [VALUE_W-1:0]  cnt_val_q;
	logic [LW:0]         need_q;
	logic [NW-1:0]       nfree_q;
	logic [AW-1:0]       root_z_q;
	logic [AW-1:0]       root_o_q;
	node_t               rd_q;
	logic [AW-1:0]       rd_idx_q;
	logic                rd_root_q;
	logic [STATUS_W-1:0] st_q;
	logic                outv_q;
	logic [VALUE_W-1:0]  out_value_q;
	logic [STATUS_W-1:0] out_status_q;

	logic                  kbit;
	logic                  pref;
	logic [AW-1:0]         pref_idx;
	logic [AW-1:0]         alt_idx;
	logic [AW-1:0]         rd_addr;
	node_t                 root_view;
	node_t                 rd_view;
	node_t                 adv_node;
	node_t                 link_node;
	node_t                 new_node;
	logic [AW-1:0]         new_idx;
	logic                  mem_we;
	logic [AW-1:0]         mem_wa;
	node_t                 mem_wd;
	logic [KEY_BITS+VALUE_W-1:0] key_ext;
	logic [KEY_BITS+VALUE_W-1:0] ans_ext;
	logic [VALUE_W+COUNT_BITS-1:0] cnt_ext;
	logic [MW-1:0]         mex_cnt;
	logic [MW-1:0]         mex_lim;

	always_comb begin
		kbit = key_q[lvl_q];
		case (op_q)
			REQ_MAXX: pref = ~kbit;
			REQ_MEX:  pref = 1'b0;
			default:  pref = kbit;
		endcase
		pref_idx  = pref ? cur_q.oc : cur_q.zc;
		alt_idx   = pref ? cur_q.zc : cur_q.oc;
		rd_addr   = cmd.rd_alt ? alt_idx : pref_idx;
		root_view = '{zc: root_z_q, oc: root_o_q, cnt: '0};
		rd_view   = rd_root_q ? root_view : rd_q;
		adv_node  = rd_view;
		if (cmd.wr == WR_INC) begin
			adv_node.cnt = rd_view.cnt + COUNT_BITS'(1);
		end
		new_idx   = nfree_q[AW-1:0];
		link_node = cur_q;
		if (pref) begin
			link_node.oc = new_idx;
		end else begin
			link_node.zc = new_idx;
		end
		new_node  = '{zc: '0, oc: '0, cnt: COUNT_BITS'(1)};
		key_ext   = {{KEY_BITS{1'b0}}, key};
		ans_ext   = {{VALUE_W{1'b0}}, ans_q};
		cnt_ext   = {{VALUE_W{1'b0}}, rd_view.cnt};
		mex_cnt   = {{KEY_BITS{1'b0}}, rd_view.cnt};
		mex_lim   = MW'(1) << lvl_q;
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = rd_idx_q;
		mem_wd = rd_view;
		case (cmd.wr)
			WR_INC: begin
				mem_we = 1'b1;
				mem_wd.cnt = rd_view.cnt + COUNT_BITS'(1);
			end
			WR_DEC: begin
				mem_we = 1'b1;
				mem_wd.cnt = rd_view.cnt - COUNT_BITS'(1);
			end
			WR_LINK: begin
				mem_we = (cur_idx_q != '0);
				mem_wa = cur_idx_q;
				mem_wd = link_node;
			end
			WR_NEW: begin
				mem_we = 1'b1;
				mem_wa = new_idx;
				mem_wd = new_node;
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			node_mem[mem_wa] <= mem_wd;
		end
		if (cmd.rd) begin
			rd_q <= node_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_z_q  <= '0;
			root_o_q  <= '0;
			nfree_q   <= NW'(1);
			rd_root_q <= 1'b0;
			outv_q    <= 1'b0;
			st_q      <= ST_OK;
			op_q      <= REQ_INSERT;
			lvl_q     <= '0;
		end else begin
			if (cmd.ld) begin
				op_q  <= req_type;
				st_q  <= ST_OK;
				lvl_q <= LW'(KEY_BITS - 1);
			end
			if (cmd.root) begin
				lvl_q <= LW'(KEY_BITS - 1);
			end
			if (cmd.adv || cmd.wr == WR_NEW) begin
				lvl_q <= lvl_q - LW'(1);
			end
			if (cmd.rd) begin
				rd_root_q <= (rd_addr == '0);
			end
			if (cmd.wr == WR_LINK && cur_idx_q == '0) begin
				if (pref) begin
					root_o_q <= new_idx;
				end else begin
					root_z_q <= new_idx;
				end
			end
			if (cmd.wr == WR_NEW) begin
				nfree_q <= nfree_q + NW'(1);
			end
			if (cmd.st_we) begin
				st_q <= cmd.st;
			end
			if (cmd.out_ld) begin
				outv_q <= 1'b1;
			end else if (out_ready) begin
				outv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			key_q     <= key_ext[KEY_BITS-1:0];
			ans_q     <= '0;
			cnt_val_q <= '0;
			need_q    <= '0;
		end
		if (cmd.ld || cmd.root) begin
			cur_idx_q <= '0;
			cur_q     <= root_view;
		end
		if (cmd.adv) begin
			cur_idx_q <= rd_idx_q;
			cur_q     <= adv_node;
		end
		if (cmd.wr == WR_NEW) begin
			cur_idx_q <= new_idx;
			cur_q     <= new_node;
		end
		if (cmd.rd) begin
			rd_idx_q <= rd_addr;
		end
		if (cmd.ans_clr) begin
			ans_q <= '0;
		end else if (cmd.ans_bit) begin
			ans_q[lvl_q] <= 1'b1;
		end
		if (cmd.ans_cnt) begin
			cnt_val_q <= cnt_ext[VALUE_W-1:0];
		end
		if (cmd.need_set) begin
			need_q <= {1'b0, lvl_q} + (LW+1)'(1);
		end
		if (cmd.out_ld) begin
			out_value_q  <= (op_q == REQ_COUNT) ? cnt_val_q : ans_ext[VALUE_W-1:0];
			out_status_q <= st_q;
		end
	end

	always_comb begin
		sts.op        = op_q;
		sts.pref_zero = (pref_idx == '0);
		sts.alt_zero  = (alt_idx == '0);
		sts.rd_live   = !rd_root_q && (rd_view.cnt != '0);
		sts.rd_sat    = &rd_view.cnt;
		sts.mex_lo    = (mex_cnt < mex_lim);
		sts.lvl_zero  = (lvl_q == '0);
		sts.lvl_top   = (lvl_q == LW'(KEY_BITS - 1));
		sts.fit       = (33'(nfree_q) + 33'(need_q)) <= 33'(POOL_NODES);
		sts.out_busy  = outv_q && !out_ready;
	end

	assign out_valid = outv_q;
	assign value     = out_value_q;
	assign status    = out_status_q;

endmodule

// ===== hw/rtl/cbxt_ctrl.sv =====
// cbxt_ctrl: request sequencer of the counting binary xor trie; walks
// the trie level by level through commands to cbxt_dp, uses cbxt_pkg
module cbxt_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_take,
	input  logic [cbxt_pkg::REQ_W-1:0] req_type,
	output logic                       in_ready,
	input  cbxt_pkg::sts_t             sts,
	output cbxt_pkg::cmd_t             cmd
);
	import cbxt_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_I1S  = 5'd1;
	localparam logic [4:0] S_I1E  = 5'd2;
	localparam logic [4:0] S_I1F  = 5'd3;
	localparam logic [4:0] S_I2S  = 5'd4;
	localparam logic [4:0] S_I2E  = 5'd5;
	localparam logic [4:0] S_I2N  = 5'd6;
	localparam logic [4:0] S_CS   = 5'd7;
	localparam logic [4:0] S_CE   = 5'd8;
	localparam logic [4:0] S_RS   = 5'd9;
	localparam logic [4:0] S_RE   = 5'd10;
	localparam logic [4:0] S_XS   = 5'd11;
	localparam logic [4:0] S_XE   = 5'd12;
	localparam logic [4:0] S_XA   = 5'd13;
	localparam logic [4:0] S_MS   = 5'd14;
	localparam logic [4:0] S_ME   = 5'd15;
	localparam logic [4:0] S_MA   = 5'd16;
	localparam logic [4:0] S_BAD  = 5'd17;
	localparam logic [4:0] S_DONE = 5'd18;

	logic [4:0] state_q;
	logic [4:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_take) begin
					cmd.ld = 1'b1;
					unique case (req_type) inside
						REQ_INSERT:           state_d = S_I1S;
						REQ_REMOVE, REQ_COUNT: state_d = S_CS;
						REQ_MINX, REQ_MAXX:   state_d = S_XS;
						REQ_MEX:              state_d = S_MS;
						default:              state_d = S_BAD;
					endcase
				end
			end
			S_I1S: begin
				if (sts.pref_zero) begin
					cmd.need_set = 1'b1;
					state_d = S_I1F;
				end else begin
					cmd.rd = 1'b1;
					state_d = S_I1E;
				end
			end
			S_I1E: begin
				if (sts.rd_sat) begin
					cmd.st_we = 1'b1;
					cmd.st    = ST_SAT;
					state_d = S_DONE;
				end else begin
					cmd.adv = 1'b1;
					state_d = sts.lvl_zero ? S_I1F : S_I1S;
				end
			end
			S_I1F: begin
				if (sts.fit) begin
					cmd.root = 1'b1;
					state_d = S_I2S;
				end else begin
					cmd.st_we = 1'b1;
					cmd.st    = ST_FULL;
					state_d = S_DONE;
				end
			end
			S_I2S: begin
				if (sts.pref_zero) begin
					cmd.wr = WR_LINK;
					state_d = S_I2N;
				end else begin
					cmd.rd = 1'b1;
					state_d = S_I2E;
				end
			end
			S_I2E: begin
				cmd.wr  = WR_INC;
				cmd.adv = 1'b1;
				state_d = sts.lvl_zero ? S_DONE : S_I2S;
			end
			S_I2N: begin
				cmd.wr = WR_NEW;
				state_d = sts.lvl_zero ? S_DONE : S_I2S;
			end
			S_CS: begin
				if (sts.pref_zero) begin
					cmd.st_we = 1'b1;
					cmd.st    = ST_ABSENT;
					state_d = S_DONE;
				end else begin
					cmd.rd = 1'b1;
					state_d = S_CE;
				end
			end
			S_CE: begin
				if (!sts.rd_live) begin
					cmd.st_we = 1'b1;
					cmd.st    = ST_ABSENT;
					state_d = S_DONE;
				end else if (!sts.lvl_zero) begin
					cmd.adv = 1'b1;
					state_d = S_CS;
				end else if (sts.op == REQ_COUNT) begin
					cmd.ans_cnt = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.root = 1'b1;
					state_d = S_RS;
				end
			end
			S_RS: begin
				if (sts.pref_zero) begin
					state_d = S_DONE;
				end else begin
					cmd.rd = 1'b1;
					state_d = S_RE;
				end
			end
			S_RE: begin
				cmd.wr  = WR_DEC;
				cmd.adv = 1'b1;
				state_d = sts.lvl_zero ? S_DONE : S_RS;
			end
			S_XS: begin
				cmd.rd = 1'b1;
				state_d = S_XE;
			end
			S_XE: begin
				if (sts.rd_live) begin
					cmd.ans_bit = (sts.op == REQ_MAXX);
					cmd.adv     = 1'b1;
					state_d = sts.lvl_zero ? S_DONE : S_XS;
				end else begin
					cmd.ans_bit = (sts.op == REQ_MINX);
					cmd.rd      = 1'b1;
					cmd.rd_alt  = 1'b1;
					state_d = S_XA;
				end
			end
			S_XA: begin
				if (sts.lvl_top && !sts.rd_live) begin
					cmd.ans_clr = 1'b1;
					cmd.st_we   = 1'b1;
					cmd.st      = ST_ABSENT;
					state_d = S_DONE;
				end else begin
					cmd.adv = 1'b1;
					state_d = sts.lvl_zero ? S_DONE : S_XS;
				end
			end
			S_MS: begin
				if (sts.pref_zero) begin
					state_d = S_DONE;
				end else begin
					cmd.rd = 1'b1;
					state_d = S_ME;
				end
			end
			S_ME: begin
				if (sts.mex_lo) begin
					cmd.adv = 1'b1;
					state_d = sts.lvl_zero ? S_DONE : S_MS;
				end else begin
					cmd.ans_bit = 1'b1;
					if (sts.alt_zero) begin
						state_d = S_DONE;
					end else begin
						cmd.rd     = 1'b1;
						cmd.rd_alt = 1'b1;
						state_d = S_MA;
					end
				end
			end
			S_MA: begin
				cmd.adv = 1'b1;
				state_d = sts.lvl_zero ? S_DONE : S_MS;
			end
			S_BAD: begin
				cmd.st_we = 1'b1;
				cmd.st    = ST_ABSENT;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_ld = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

// ===== hw/rtl/counting_binary_xor_trie.sv =====
// counting_binary_xor_trie: top level joining cbxt_ctrl and cbxt_dp to
// the stream ports; uses cbxt_pkg
//
// A multiset of keys kept as a binary trie of counted prefix nodes in a
// pool of POOL_NODES - 1 usable nodes (index 0 is the null link) that
// are never freed. One request at a time: each pass walks up to KEY_BITS
// levels, each level a node memory read and then its evaluation, with
// min/max xor and mex reading the other child as well where needed;
// remove and insert make two passes. An idle block needs no clearing
// pass after reset. The result waits in an output register; a new
// request is taken once the previous one has been handed to that
// register.
module counting_binary_xor_trie #(
	parameter int KEY_BITS   = 30,
	parameter int POOL_NODES = 4096,
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // key[29:0]
	input  logic [7:0]  s_axis_tuser,  // req_type[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // value[29:0]
	output logic [7:0]  m_axis_tuser   // status[1:0]
);
	import cbxt_pkg::*;

	cmd_t                cmd;
	sts_t                sts;
	logic                in_take;
	logic [VALUE_W-1:0]  value;
	logic [STATUS_W-1:0] status;

	assign in_take = s_axis_tvalid && s_axis_tready;

	cbxt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_take  (in_take),
		.req_type (s_axis_tuser[REQ_W-1:0]),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cbxt_dp #(
		.KEY_BITS   (KEY_BITS),
		.POOL_NODES (POOL_NODES),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_type  (s_axis_tuser[REQ_W-1:0]),
		.key       (s_axis_tdata[VALUE_W-1:0]),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.value     (value),
		.status    (status)
	);

	assign m_axis_tdata = {{(32-VALUE_W){1'b0}}, value};
	assign m_axis_tuser = {{(8-STATUS_W){1'b0}}, status};

endmodule
